// ===== rtl/core/tsre_pkg.sv =====
// Package for the two-stack rotate engine: request codes, internal operation
// codes and the command/status structs between controller and datapath.
// No dependencies.
package tsre_pkg;

    localparam int REQ_W       = 3;
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int COUNT_OUT_W = 10;

    localparam logic [REQ_W-1:0] REQ_LOAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SWAP = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ROT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RROT = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_LOAD = 3'd1,
        OP_SWAP = 3'd2,
        OP_PUSH = 3'd3,
        OP_ROT  = 3'd4,
        OP_RROT = 3'd5
    } t_op;

    typedef struct packed {
        logic exec;
        logic fin;
        t_op  op;
        logic sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] empty;
        logic [1:0] full;
        logic [1:0] multi;
    } t_status;

endpackage

// ===== rtl/core/tsre_datapath.sv =====
// Datapath of the two-stack rotate engine: both ring buffers, head pointers,
// entry counts and cached top entries.
// Depends on tsre_pkg.
module tsre_datapath #(
    parameter int DEPTH       = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tsre_pkg::t_cmd                           i_cmd,
    input  logic signed [tsre_pkg::IN_VALUE_W-1:0]   i_load_value,
    output tsre_pkg::t_status                        o_status,
    output logic signed [tsre_pkg::OUT_VALUE_W-1:0]  o_top_of_a,
    output logic signed [tsre_pkg::OUT_VALUE_W-1:0]  o_top_of_b,
    output logic [tsre_pkg::COUNT_OUT_W-1:0]         o_entries_in_a,
    output logic [tsre_pkg::COUNT_OUT_W-1:0]         o_entries_in_b
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = tsre_pkg::OUT_VALUE_W;
    localparam int NW = tsre_pkg::COUNT_OUT_W;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] p, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW+1)'(p) + (CW+1)'(c);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]          r_head  [2];
    logic [AW-1:0]          n_head  [2];
    logic [CW-1:0]          r_count [2];
    logic [CW-1:0]          n_count [2];
    logic [VALUE_WIDTH-1:0] r_top   [2];
    logic [VALUE_WIDTH-1:0] n_top   [2];
    logic                   r_single;
    logic                   n_single;

    logic [1:0]             we;
    logic [AW-1:0]          waddr   [2];
    logic [AW-1:0]          raddr   [2];
    logic [VALUE_WIDTH-1:0] wdata   [2];
    logic [VALUE_WIDTH-1:0] r_rdata [2];

    logic                   s;
    logic                   d;
    logic [AW-1:0]          d_head;
    logic [VALUE_WIDTH+tsre_pkg::IN_VALUE_W-1:0] ld_ext;
    logic [VALUE_WIDTH-1:0] ld_val;

    assign ld_ext = {{VALUE_WIDTH{i_load_value[tsre_pkg::IN_VALUE_W-1]}}, i_load_value};
    assign ld_val = ld_ext[VALUE_WIDTH-1:0];

    assign s      = i_cmd.sel;
    assign d      = ~i_cmd.sel;
    assign d_head = f_dec(r_head[d]);

    // ring buffers: one write and one registered read per cycle each
    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_ring
            logic [VALUE_WIDTH-1:0] mem [DEPTH];
            always_ff @(posedge i_clk) begin
                if (we[g]) begin
                    mem[waddr[g]] <= wdata[g];
                end
                r_rdata[g] <= mem[raddr[g]];
            end
        end
    endgenerate

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_top    = r_top;
        n_single = r_single;
        we       = '0;
        waddr    = '{default: '0};
        raddr    = '{default: '0};
        wdata    = '{default: '0};
        if (i_cmd.exec) begin
            case (i_cmd.op)
                tsre_pkg::OP_LOAD: begin
                    we[0]      = 1'b1;
                    waddr[0]   = f_add(r_head[0], r_count[0]);
                    wdata[0]   = ld_val;
                    n_count[0] = r_count[0] + CW'(1);
                    if (r_count[0] == '0) begin
                        n_top[0] = ld_val;
                    end
                end
                tsre_pkg::OP_SWAP: begin
                    // read-before-write: second entry comes back, old top goes in
                    raddr[s] = f_inc(r_head[s]);
                    we[s]    = 1'b1;
                    waddr[s] = f_inc(r_head[s]);
                    wdata[s] = r_top[s];
                end
                tsre_pkg::OP_PUSH: begin
                    we[d]      = 1'b1;
                    waddr[d]   = d_head;
                    wdata[d]   = r_top[s];
                    n_head[d]  = d_head;
                    n_count[d] = r_count[d] + CW'(1);
                    n_top[d]   = r_top[s];
                    raddr[s]   = f_inc(r_head[s]);
                    n_head[s]  = f_inc(r_head[s]);
                    n_count[s] = r_count[s] - CW'(1);
                end
                tsre_pkg::OP_ROT: begin
                    we[s]     = 1'b1;
                    waddr[s]  = f_add(r_head[s], r_count[s]);
                    wdata[s]  = r_top[s];
                    raddr[s]  = f_inc(r_head[s]);
                    n_head[s] = f_inc(r_head[s]);
                    n_single  = (r_count[s] == CW'(1));
                end
                tsre_pkg::OP_RROT: begin
                    raddr[s]  = f_add(r_head[s], r_count[s] - CW'(1));
                    n_head[s] = f_dec(r_head[s]);
                end
                default: begin
                end
            endcase
        end else if (i_cmd.fin) begin
            case (i_cmd.op)
                tsre_pkg::OP_SWAP: begin
                    we[s]    = 1'b1;
                    waddr[s] = r_head[s];
                    wdata[s] = r_rdata[s];
                    n_top[s] = r_rdata[s];
                end
                tsre_pkg::OP_PUSH: begin
                    n_top[s] = r_rdata[s];
                end
                tsre_pkg::OP_ROT: begin
                    if (!r_single) begin
                        n_top[s] = r_rdata[s];
                    end
                end
                tsre_pkg::OP_RROT: begin
                    we[s]    = 1'b1;
                    waddr[s] = r_head[s];
                    wdata[s] = r_rdata[s];
                    n_top[s] = r_rdata[s];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '{default: '0};
            r_count  <= '{default: '0};
            r_single <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_single <= n_single;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            o_status.empty[i] = (r_count[i] == '0);
            o_status.full[i]  = (r_count[i] == CW'(DEPTH));
            o_status.multi[i] = (r_count[i] >= CW'(2));
        end
    end

    logic [VALUE_WIDTH+OW-1:0] top_ext_a;
    logic [VALUE_WIDTH+OW-1:0] top_ext_b;
    logic [CW+NW-1:0]          cnt_ext_a;
    logic [CW+NW-1:0]          cnt_ext_b;

    assign top_ext_a = {{OW{r_top[0][VALUE_WIDTH-1]}}, r_top[0]};
    assign top_ext_b = {{OW{r_top[1][VALUE_WIDTH-1]}}, r_top[1]};
    assign cnt_ext_a = {{NW{1'b0}}, r_count[0]};
    assign cnt_ext_b = {{NW{1'b0}}, r_count[1]};

    assign o_top_of_a     = o_status.empty[0] ? '0 : top_ext_a[OW-1:0];
    assign o_top_of_b     = o_status.empty[1] ? '0 : top_ext_b[OW-1:0];
    assign o_entries_in_a = cnt_ext_a[NW-1:0];
    assign o_entries_in_b = cnt_ext_b[NW-1:0];

`ifndef SYNTHESIS
    a_count_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] <= CW'(DEPTH))
        else $error("stack A count beyond depth");
    a_count_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[1] <= CW'(DEPTH))
        else $error("stack B count beyond depth");
`endif

endmodule

// ===== rtl/core/tsre_ctrl.sv =====
// Controller of the two-stack rotate engine: request decode and checks, the
// two-state sequencer and the result strobe.
// Depends on tsre_pkg.
module tsre_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tsre_pkg::REQ_W-1:0]     i_req_type,
    input  logic                           i_which_stack,
    input  tsre_pkg::t_status              i_status,
    output tsre_pkg::t_cmd                 o_cmd,
    output logic                           o_done,
    output logic                           o_op_error
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIN  = 2'b10
    } t_state;

    t_state        r_state;
    t_state        n_state;
    tsre_pkg::t_op r_op;
    tsre_pkg::t_op dec_op;
    logic          r_sel;
    logic          r_done;
    logic          r_err;
    logic          accept;
    logic          s;
    logic          d;

    assign busy   = (r_state == S_FIN);
    assign accept = start && !busy;
    assign s      = i_which_stack;
    assign d      = ~i_which_stack;

    always_comb begin
        case (i_req_type)
            tsre_pkg::REQ_LOAD:
                dec_op = i_status.full[0] ? tsre_pkg::OP_NONE : tsre_pkg::OP_LOAD;
            tsre_pkg::REQ_SWAP:
                dec_op = i_status.multi[s] ? tsre_pkg::OP_SWAP : tsre_pkg::OP_NONE;
            tsre_pkg::REQ_PUSH:
                dec_op = (i_status.empty[s] || i_status.full[d]) ?
                         tsre_pkg::OP_NONE : tsre_pkg::OP_PUSH;
            tsre_pkg::REQ_ROT:
                dec_op = i_status.empty[s] ? tsre_pkg::OP_NONE : tsre_pkg::OP_ROT;
            tsre_pkg::REQ_RROT:
                dec_op = i_status.empty[s] ? tsre_pkg::OP_NONE : tsre_pkg::OP_RROT;
            default:
                dec_op = tsre_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        o_cmd.exec = accept;
        o_cmd.fin  = busy;
        o_cmd.op   = busy ? r_op : dec_op;
        o_cmd.sel  = busy ? r_sel : i_which_stack;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_FIN : S_IDLE;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= dec_op;
            r_sel <= i_which_stack;
            r_err <= (dec_op == tsre_pkg::OP_NONE);
        end
    end

    assign o_done     = r_done;
    assign o_op_error = r_err;

`ifndef SYNTHESIS
    a_accept_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FIN))
        else $error("accepted item did not enter finish step");
    a_fin_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_done)
        else $error("finish step gave no result strobe");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");
`endif

endmodule

// ===== rtl/core/two_stack_rotate_engine.sv =====
// Top level of the two-stack rotate engine: controller plus datapath.
// Depends on tsre_pkg, tsre_ctrl and tsre_datapath.
//
// Usage:
//   Command channel: drive i_req_type, i_which_stack and i_load_value with
//   start high; the item is taken at a rising edge where start is high and
//   busy is low. busy is high while a taken item is in its finish step.
//   Result channel: o_done is high for exactly one cycle; o_top_of_a,
//   o_top_of_b, o_entries_in_a, o_entries_in_b and o_op_error are valid in
//   that cycle. The receiver cannot stall the block and must take it then.
//   Timing: busy holds off a new item while the last one is in its finish
//   step; the result strobe is registered from that step. The execute step
//   does the ring write and the read of the next entry, the finish step writes
//   the fetched entry back and loads the cached top, as each request needs;
//   each ring is one memory with one write and one registered read port.
//   Reset (i_rst_n low, synchronous) empties both stacks and clears the
//   sequencer; buffer contents are left as they are.
//   A request that cannot be done (empty or short source, full destination,
//   unknown code) changes nothing and returns o_op_error high.
module two_stack_rotate_engine #(
    parameter int DEPTH       = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [tsre_pkg::REQ_W-1:0]               i_req_type,
    input  logic                                     i_which_stack,
    input  logic signed [tsre_pkg::IN_VALUE_W-1:0]   i_load_value,
    output logic                                     o_done,
    output logic signed [tsre_pkg::OUT_VALUE_W-1:0]  o_top_of_a,
    output logic signed [tsre_pkg::OUT_VALUE_W-1:0]  o_top_of_b,
    output logic [tsre_pkg::COUNT_OUT_W-1:0]         o_entries_in_a,
    output logic [tsre_pkg::COUNT_OUT_W-1:0]         o_entries_in_b,
    output logic                                     o_op_error
);

    tsre_pkg::t_cmd    cmd;
    tsre_pkg::t_status status;

    tsre_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_which_stack (i_which_stack),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_done        (o_done),
        .o_op_error    (o_op_error)
    );

    tsre_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_load_value   (i_load_value),
        .o_status       (status),
        .o_top_of_a     (o_top_of_a),
        .o_top_of_b     (o_top_of_b),
        .o_entries_in_a (o_entries_in_a),
        .o_entries_in_b (o_entries_in_b)
    );

endmodule
